@@ hdl/pwli_pkg.sv @@
// Shared types and constants for the piecewise-linear interpolation table.
// Used by pwli_table_mem, pwli_div and piecewise_linear_table_interp_top.
package pwli_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ValW  = 31;
  localparam int unsigned StW   = 3;

  localparam logic signed [DataW-1:0] OneQ16  = 32'sd65536;
  localparam logic signed [DataW-1:0] KeyMax  = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] RawInit = -32'sd1;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [StW-1:0] {
    ST_OK         = 3'd0,
    ST_NEG_ENERGY = 3'd1,
    ST_UNSORTED   = 3'd2,
    ST_NEG_TRANS  = 3'd3,
    ST_FULL       = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_Q_LAST,
    S_Q_FIRST,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_DIV,
    S_A_LAST,
    S_OUT
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

@@ hdl/piecewise_linear_table_interp_top.sv @@
// Piecewise-linear interpolation table, top level: sequencer and result register.
// Instantiates pwli_table_mem and pwli_div; depends on pwli_pkg.
//
// Input words (in_op, in_energy, in_trans_value) are taken when in_valid is
// high and in_stall low. in_stall is high while a word is being worked on.
// Every word gives exactly one result word on out_value, out_status and
// out_entry_count, held in an output register until out_stall is low.
// The next input word is taken as soon as the result has been loaded, even
// if that result is still stalled.
// Clear, invalid op and rejected appends go straight to the output state;
// appends to a non-empty table first read the last entry; queries read the
// last key, then the first key unless clamped at the last. An interpolating
// query then runs a binary search over the breakpoints, a read and a check
// state per probe (up to log2(TABLE_DEPTH) probes), then the bit-serial
// divider: a multiply step, a load step and 31 quotient steps.
// Reset (synchronous, rst_n low) leaves one breakpoint (0, 1.0), no pending
// result, and no memory sweep is needed. While a result is stalled, the next
// result waits in the output state; no word is lost.
module piecewise_linear_table_interp_top #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_op,
  input  logic signed [pwli_pkg::DataW-1:0] in_energy,
  input  logic signed [pwli_pkg::DataW-1:0] in_trans_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pwli_pkg::ValW-1:0]         out_value,
  output logic [pwli_pkg::StW-1:0]          out_status,
  output logic [CW-1:0]                     out_entry_count
);
  import pwli_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t                  state_r, state_nxt;
  logic signed [DataW-1:0] e_r, t_r, last_raw_r;
  logic signed [DataW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [CW-1:0]           cnt_r;
  logic [AW-1:0]           lo_r, hi_r, mid_r;
  logic [ValW-1:0]         val_r;
  status_t                 st_r;
  logic                    neg_r;
  logic                    out_valid_r;
  logic [ValW-1:0]         out_value_r;
  logic [StW-1:0]          out_status_r;
  logic [CW-1:0]           out_cnt_r;

  mem_ctl_t                mctl;
  logic [AW-1:0]           maddr;
  logic signed [DataW-1:0] mwkey, mwtrans, rkey, rtrans;

  logic                    div_start, div_done;
  logic [ValW-1:0]         div_a, div_b, div_d, div_q;

  logic                    accept;
  logic [AW-1:0]           last_idx, mid;
  logic signed [DataW-1:0] k_bump, dy;
  logic signed [DataW-1:0] e_nxt, t_nxt, last_raw_nxt;
  logic signed [DataW-1:0] x1_nxt, y1_nxt, x2_nxt, y2_nxt;
  logic [CW-1:0]           cnt_nxt;
  logic [AW-1:0]           lo_nxt, hi_nxt, mid_nxt;
  logic [ValW-1:0]         val_nxt;
  status_t                 st_nxt;
  logic                    neg_nxt, load_out;
  op_t                     op;

  pwli_table_mem #(.AW(AW)) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mctl),
    .addr     (maddr),
    .wr_key   (mwkey),
    .wr_trans (mwtrans),
    .rd_key   (rkey),
    .rd_trans (rtrans)
  );

  pwli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q)
  );

  assign accept   = in_valid && !in_stall;
  assign op       = op_t'(in_op);
  assign last_idx = AW'(cnt_r - 1'b1);
  assign mid      = AW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign k_bump   = (e_r == KeyMax) ? e_r : e_r + 32'sd1;
  assign dy       = y2_r - y1_r;

  always_comb begin
    state_nxt    = state_r;
    e_nxt        = e_r;
    t_nxt        = t_r;
    last_raw_nxt = last_raw_r;
    x1_nxt       = x1_r;
    y1_nxt       = y1_r;
    x2_nxt       = x2_r;
    y2_nxt       = y2_r;
    cnt_nxt      = cnt_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    val_nxt      = val_r;
    st_nxt       = st_r;
    neg_nxt      = neg_r;
    mctl         = '0;
    maddr        = '0;
    mwkey        = e_r;
    mwtrans      = t_r;
    div_start    = 1'b0;
    div_a        = ValW'(e_r - x1_r);
    div_b        = dy[DataW-1] ? ValW'(-dy) : ValW'(dy);
    div_d        = ValW'(x2_r - x1_r);
    load_out     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          e_nxt   = in_energy;
          t_nxt   = in_trans_value;
          val_nxt = '0;
          st_nxt  = ST_OK;
          state_nxt = S_OUT;
          unique case (op)
            OP_QUERY: begin
              if (cnt_r == '0) begin
                val_nxt = ValW'(OneQ16);
              end else begin
                mctl.rd   = 1'b1;
                maddr     = last_idx;
                state_nxt = S_Q_LAST;
              end
            end
            OP_APPEND: begin
              if (in_energy < 0) begin
                st_nxt = ST_NEG_ENERGY;
              end else if (in_energy < last_raw_r) begin
                st_nxt = ST_UNSORTED;
              end else if (in_trans_value < 0) begin
                st_nxt = ST_NEG_TRANS;
              end else if (cnt_r == '0) begin
                mctl.wr      = 1'b1;
                maddr        = '0;
                mwkey        = in_energy;
                mwtrans      = in_trans_value;
                cnt_nxt      = CW'(1);
                last_raw_nxt = in_energy;
              end else begin
                mctl.rd   = 1'b1;
                maddr     = last_idx;
                state_nxt = S_A_LAST;
              end
            end
            OP_CLEAR: begin
              cnt_nxt      = '0;
              last_raw_nxt = RawInit;
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end

      S_Q_LAST: begin
        if (e_r >= rkey) begin
          val_nxt   = rtrans[DataW-1] ? '0 : rtrans[ValW-1:0];
          state_nxt = S_OUT;
        end else begin
          x2_nxt    = rkey;
          y2_nxt    = rtrans;
          hi_nxt    = last_idx;
          mctl.rd   = 1'b1;
          maddr     = '0;
          state_nxt = S_Q_FIRST;
        end
      end

      S_Q_FIRST: begin
        if (e_r <= rkey) begin
          val_nxt   = rtrans[DataW-1] ? '0 : rtrans[ValW-1:0];
          state_nxt = S_OUT;
        end else begin
          x1_nxt    = rkey;
          y1_nxt    = rtrans;
          lo_nxt    = '0;
          state_nxt = S_SRCH_RD;
        end
      end

      S_SRCH_RD: begin
        if ({1'b0, hi_r} - {1'b0, lo_r} > (AW + 1)'(1)) begin
          mctl.rd   = 1'b1;
          maddr     = mid;
          mid_nxt   = mid;
          state_nxt = S_SRCH_CHK;
        end else begin
          // bracket found: x1 <= e < x2
          div_start = 1'b1;
          neg_nxt   = dy[DataW-1];
          state_nxt = S_DIV;
        end
      end

      S_SRCH_CHK: begin
        if (rkey <= e_r) begin
          lo_nxt = mid_r;
          x1_nxt = rkey;
          y1_nxt = rtrans;
        end else begin
          hi_nxt = mid_r;
          x2_nxt = rkey;
          y2_nxt = rtrans;
        end
        state_nxt = S_SRCH_RD;
      end

      S_DIV: begin
        if (div_done) begin
          val_nxt   = neg_r ? ValW'(y1_r) - div_q : ValW'(y1_r) + div_q;
          state_nxt = S_OUT;
        end
      end

      S_A_LAST: begin
        state_nxt = S_OUT;
        if (e_r <= rkey && k_bump <= rkey) begin
          // same key again: overwrite the last entry
          mctl.wr      = 1'b1;
          maddr        = last_idx;
          mwkey        = k_bump;
          last_raw_nxt = e_r;
        end else if (cnt_r == CW'(TABLE_DEPTH)) begin
          st_nxt = ST_FULL;
        end else begin
          mctl.wr      = 1'b1;
          maddr        = AW'(cnt_r);
          mwkey        = (e_r <= rkey) ? k_bump : e_r;
          cnt_nxt      = cnt_r + 1'b1;
          last_raw_nxt = e_r;
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CW'(1);
      last_raw_r  <= RawInit;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      last_raw_r <= last_raw_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    t_r   <= t_nxt;
    x1_r  <= x1_nxt;
    y1_r  <= y1_nxt;
    x2_r  <= x2_nxt;
    y2_r  <= y2_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    val_r <= val_nxt;
    st_r  <= st_nxt;
    neg_r <= neg_nxt;
    if (load_out) begin
      out_value_r  <= val_r;
      out_status_r <= st_r;
      out_cnt_r    <= cnt_r;
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_cnt_r;

endmodule

@@ hdl/pwli_table_mem.sv @@
// Breakpoint store: key and transmission memories with a registered read port.
// Entry zero reads as (0, 1.0) after reset until it is first written.
// Depends on pwli_pkg.
module pwli_table_mem #(
  parameter int unsigned AW = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pwli_pkg::mem_ctl_t             ctl,
  input  logic [AW-1:0]                  addr,
  input  logic signed [pwli_pkg::DataW-1:0] wr_key,
  input  logic signed [pwli_pkg::DataW-1:0] wr_trans,
  output logic signed [pwli_pkg::DataW-1:0] rd_key,
  output logic signed [pwli_pkg::DataW-1:0] rd_trans
);
  import pwli_pkg::*;

  localparam int unsigned Depth = 1 << AW;

  logic signed [DataW-1:0] key_mem   [Depth];
  logic signed [DataW-1:0] trans_mem [Depth];
  logic signed [DataW-1:0] key_q_r, trans_q_r;
  logic                    e0_init_r;
  logic                    rd_zero_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      key_mem[addr]   <= wr_key;
      trans_mem[addr] <= wr_trans;
    end
    if (ctl.rd) begin
      key_q_r   <= key_mem[addr];
      trans_q_r <= trans_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_init_r <= 1'b1;
      rd_zero_r <= 1'b0;
    end else begin
      if (ctl.wr && addr == '0) begin
        e0_init_r <= 1'b0;
      end
      if (ctl.rd) begin
        rd_zero_r <= e0_init_r && (addr == '0);
      end
    end
  end

  // entry zero keeps its reset value until overwritten
  assign rd_key   = rd_zero_r ? '0 : key_q_r;
  assign rd_trans = rd_zero_r ? OneQ16 : trans_q_r;

endmodule

@@ hdl/pwli_div.sv @@
// Scaled-slope unit: q = a * b / d, truncated, for a < d < 2^31, b < 2^31.
// Multiply, load, then one quotient bit per cycle. Depends on pwli_pkg.
module pwli_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pwli_pkg::ValW-1:0] a,
  input  logic [pwli_pkg::ValW-1:0] b,
  input  logic [pwli_pkg::ValW-1:0] d,
  output logic                      done,
  output logic [pwli_pkg::ValW-1:0] q
);
  import pwli_pkg::*;

  localparam int unsigned CntW = $clog2(ValW + 2);

  logic [ValW-1:0]   a_r, b_r, d_r;
  logic [2*ValW-1:0] prod_r, prod_nxt;
  logic [ValW-1:0]   rem_r, rem_nxt;
  logic [ValW-1:0]   q_r, q_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              mul_r, busy_r, done_r;
  logic [ValW:0]     trial;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    trial    = {rem_r, prod_r[ValW-1]} - {1'b0, d_r};
    prod_nxt = {prod_r[2*ValW-2:0], 1'b0};
    cnt_nxt  = cnt_r - 1'b1;
    if (!trial[ValW]) begin
      rem_nxt = trial[ValW-1:0];
      q_nxt   = {q_r[ValW-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[ValW-2:0], prod_r[ValW-1]};
      q_nxt   = {q_r[ValW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      d_r <= d;
    end
    if (mul_r) begin
      // quotient fits 31 bits, so the top half is already below d
      prod_r <= (2*ValW)'(a_r) * (2*ValW)'(b_r);
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      if (cnt_r == CntW'(ValW + 1)) begin
        // low half stays put and is shifted out from bit ValW-1
        rem_r <= prod_r[2*ValW-1:ValW];
      end else begin
        rem_r  <= rem_nxt;
        q_r    <= q_nxt;
        prod_r <= prod_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      mul_r  <= start;
      if (mul_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(ValW + 1);
      end else if (busy_r) begin
        cnt_r <= cnt_nxt;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

@@ test/piecewise_linear_table_interp_top_tb.sv @@
// Testbench for piecewise_linear_table_interp_top: random and directed words, a table
// predictor with in-order result checking, random idling on both sides.
// Depends on pwli_pkg and the block's RTL only.
`timescale 1ns / 1ps

module piecewise_linear_table_interp_top_tb;
  import pwli_pkg::*;

  localparam int Depth     = 256;
  localparam int NumItems  = 1300;
  localparam int LongHold  = 400;
  localparam int StallLim  = 5000;

  typedef struct {
    op_t               op;
    logic signed [31:0] energy;
    logic signed [31:0] trans;
  } word_t;

  typedef struct {
    logic [ValW-1:0] value;
    status_t         status;
    logic [8:0]      count;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = 2'd0;
  logic signed [31:0] in_energy = '0;
  logic signed [31:0] in_trans_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ValW-1:0] out_value;
  logic [StW-1:0] out_status;
  logic [8:0] out_entry_count;

  piecewise_linear_table_interp_top #(.TABLE_DEPTH(Depth)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_energy(in_energy), .in_trans_value(in_trans_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
    .out_status(out_status), .out_entry_count(out_entry_count)
  );

  always #4 clk = ~clk;

  word_t   pending_words[$];
  result_t expected_results[$];
  int      errors = 0;
  int      idle_max = 5;
  int      hold_req = 0;
  int      hold_done = 0;
  int      pushed = 0;

  // table copy
  longint  keys[Depth];
  longint  vals[Depth];
  int      n_entries;
  longint  last_raw;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint interp(input longint e);
    int hi;
    longint x1, x2, y1, y2;
    if (n_entries == 0) return 65536;
    if (e >= keys[n_entries-1]) return vals[n_entries-1];
    if (e <= keys[0]) return vals[0];
    hi = 1;
    while (hi < n_entries - 1 && keys[hi] <= e) hi++;
    x1 = keys[hi-1]; x2 = keys[hi]; y1 = vals[hi-1]; y2 = vals[hi];
    if (x2 <= x1) return y1;
    return y1 + ((e - x1) * (y2 - y1)) / (x2 - x1);
  endfunction

  function automatic status_t add_point(input longint e, input longint t);
    longint k;
    k = e;
    if (e < 0) return ST_NEG_ENERGY;
    if (e < last_raw) return ST_UNSORTED;
    if (t < 0) return ST_NEG_TRANS;
    if (n_entries > 0 && k <= keys[n_entries-1]) begin
      k = (e + 1 > 64'sd2147483647) ? 64'sd2147483647 : e + 1;
      if (k <= keys[n_entries-1]) begin
        keys[n_entries-1] = k;
        vals[n_entries-1] = t;
        last_raw = e;
        return ST_OK;
      end
    end
    if (n_entries >= Depth) return ST_FULL;
    keys[n_entries] = k;
    vals[n_entries] = t;
    n_entries++;
    last_raw = e;
    return ST_OK;
  endfunction

  task automatic table_step(input word_t w);
    result_t r;
    longint v;
    r.value = '0;
    r.status = ST_OK;
    case (w.op)
      OP_QUERY: begin
        v = interp(longint'(w.energy));
        if (v < 0) v = 0;
        r.value = v[ValW-1:0];
      end
      OP_APPEND: r.status = add_point(longint'(w.energy), longint'(w.trans));
      OP_CLEAR: begin
        n_entries = 0;
        last_raw = -1;
      end
      default: ;
    endcase
    r.count = n_entries[8:0];
    expected_results.push_back(r);
  endtask

  task automatic add(input op_t op, input logic signed [31:0] e, input logic signed [31:0] t);
    word_t w;
    w.op = op; w.energy = e; w.trans = t;
    pending_words.push_back(w);
    pushed++;
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // driver
  word_t cur;
  int    in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) table_step(cur);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur = pending_words.pop_front();
          in_op <= cur.op;
          in_energy <= cur.energy;
          in_trans_value <= cur.trans;
          in_valid <= 1'b1;
          in_gap = $urandom_range(0, idle_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_wait = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    result_t x;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          x = expected_results.pop_front();
          if (out_value !== x.value)
            report($sformatf("value %0d, expected %0d", out_value, x.value));
          if (out_status !== x.status)
            report($sformatf("status %0d, expected %0d", out_status, x.status));
          if (out_entry_count !== x.count)
            report($sformatf("entry_count %0d, expected %0d", out_entry_count, x.count));
        end
        out_wait = $urandom_range(0, idle_max);
      end
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        hold_cnt = LongHold;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= StallLim) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] rnd_trans();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'sh7fffffff - $urandom_range(0, 3);
      2, 3: return $urandom & 32'h7fffffff;
      default: return $urandom_range(0, 32'h0002_0000);
    endcase
  endfunction

  initial begin
    int n_app, step;
    longint e_run;
    logic signed [31:0] q;
    n_entries = 1;
    keys[0] = 0;
    vals[0] = 65536;
    last_raw = -1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset table, clamps, rejections, duplicate keys, saturation, empty table
    add(OP_QUERY, 0, 0);
    add(OP_QUERY, 32'sh80000000, 32'sh7fffffff);
    add(OP_QUERY, 32'sh7fffffff, 32'sh80000000);
    add(OP_APPEND, 32'sh80000000, 0);                // negative energy
    add(OP_APPEND, 100 << 16, 32'sh7fffffff);
    add(OP_APPEND, 50 << 16, 10);                    // unsorted
    add(OP_APPEND, 200 << 16, 32'sh80000000);        // negative transmission
    add(OP_APPEND, 100 << 16, 5000);                 // duplicate: bumped key
    add(OP_APPEND, 100 << 16, 7000);                 // bumped key again: overwrite
    add(OP_APPEND, 300 << 16, 0);
    add(OP_QUERY, 50 << 16, 0);
    add(OP_QUERY, 200 << 16, 0);
    add(OP_QUERY, (100 << 16) + 1, 0);
    add(OP_APPEND, 32'sh7fffffff, 12345);
    add(OP_APPEND, 32'sh7fffffff, 54321);            // saturated key overwrites
    add(OP_QUERY, 32'sh7ffffff0, 0);
    add(OP_NONE, 32'sh7fffffff, 32'sh7fffffff);
    add(OP_CLEAR, 0, 0);
    add(OP_QUERY, 1234, 0);                          // empty table
    add(OP_APPEND, 0, 0);
    add(OP_APPEND, 0, 65536);                        // bumped to 1
    add(OP_QUERY, 32'shffffffff, 0);
    add(OP_NONE, 0, 0);
    wait_drained();

    while (pushed < NumItems) begin
      if (pushed > 400 && hold_req == 0) hold_req = 1;
      if (pushed > 700 && pushed < 900) idle_max = 0;
      else idle_max = 5;
      if ($urandom_range(0, 3) != 0 || (pushed > 500 && pushed < 600))
        add(OP_CLEAR, $urandom, $urandom);
      // one fill past the depth, otherwise short runs
      n_app = (pushed > 500 && pushed < 600) ? Depth + 4 : $urandom_range(1, 12);
      step = (n_app > Depth) ? (1 << 20) : (1 << $urandom_range(0, 27));
      e_run = $urandom_range(0, 1 << 16);
      for (int i = 0; i < n_app; i++) begin
        // the fill keeps every key rising so the table really overflows
        case ((n_app > Depth) ? 19 : $urandom_range(0, 19))
          0: add(OP_APPEND, $urandom, rnd_trans());
          1: add(OP_APPEND, e_run - $urandom_range(1, 100), rnd_trans());
          2: add(OP_APPEND, e_run, rnd_trans());
          default: begin
            e_run += $urandom_range(1, step);
            if (e_run > 64'sd2147483647) e_run = 64'sd2147483647;
            add(OP_APPEND, e_run[31:0], rnd_trans());
          end
        endcase
        if ($urandom_range(0, 2) == 0) begin
          q = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, e_run + step);
          add(OP_QUERY, q, $urandom);
        end
      end
      for (int i = $urandom_range(0, 8); i > 0; i--) begin
        q = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, e_run + 100);
        add($urandom_range(0, 15) == 0 ? OP_NONE : OP_QUERY, q, $urandom);
      end
      if (pushed > 1000 && pushed < 1100) wait_drained();
    end
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pwli_pkg.sv
hdl/pwli_table_mem.sv
hdl/pwli_div.sv
hdl/piecewise_linear_table_interp_top.sv
test/piecewise_linear_table_interp_top_tb.sv
